@@ hw/rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg: shared definitions of the first-fit block allocator
// Arena geometry, command and status codes, and the request and result words.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_BYTES     = 2048;
    localparam int MIN_BLOCK_BYTES = 48;
    localparam int HEADER_BYTES    = 8;
    localparam int GRANULE_BYTES   = 8;
    localparam int GRANULES        = ARENA_BYTES / GRANULE_BYTES;
    localparam int MIN_GRANULES    = MIN_BLOCK_BYTES / GRANULE_BYTES;

    // Granule index width and block length width (a length can equal GRANULES).
    localparam int GRAN_AW = $clog2(GRANULES);
    localparam int LEN_W   = GRAN_AW + 1;

    localparam logic [LEN_W-1:0] LEN_ARENA = LEN_W'(GRANULES);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(MIN_GRANULES);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [11:0] request_bytes;
        logic [10:0] free_address;
    } ffba_req_t;

    typedef struct packed {
        logic [10:0] data_address;
        logic [1:0]  status;
    } ffba_rsp_t;

endpackage

@@ hw/rtl/first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit boundary-tag block allocator
// Keeps a 2048-byte arena as a chain of free and busy blocks in three tables
// and serves allocate and free commands one word at a time.
// ----------------------------------------------------------------------------
// An oversized allocate is answered from idle without a walk; other allocates
// walk the chain block by block and take an extra step to write a split tail.
// A free with a malformed address is answered from idle; otherwise the block
// there is checked, merged with free neighbours below and above, and written back.
// busy drops with the done strobe, so the next word is taken at the edge that
// ends it. After reset, busy stays high for a clearing pass over every table entry.
module first_fit_block_allocator_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ffba_pkg::ffba_req_t request,
    output logic                done,
    output ffba_pkg::ffba_rsp_t result
);

    localparam int AW = ffba_pkg::GRAN_AW;
    localparam int LW = ffba_pkg::LEN_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACHK  = 4'd1;
    localparam logic [3:0] ST_AW2   = 4'd2;
    localparam logic [3:0] ST_FCHK  = 4'd3;
    localparam logic [3:0] ST_FPREV = 4'd4;
    localparam logic [3:0] ST_FNRD  = 4'd5;
    localparam logic [3:0] ST_FNCHK = 4'd6;
    localparam logic [3:0] ST_FWR   = 4'd7;
    localparam logic [3:0] ST_CLR   = 4'd8;

    // Tables: length at block start, busy flag, free length at block end.
    logic [LW-1:0] blen_mem [ffba_pkg::GRANULES];
    logic          bsy_mem  [ffba_pkg::GRANULES];
    logic [LW-1:0] fend_mem [ffba_pkg::GRANULES];

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [LW-1:0] k_reg, k_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] rest_reg, rest_next;
    logic [AW-1:0] n_reg, n_next;
    logic          done_reg, done_next;
    ffba_pkg::ffba_rsp_t result_reg, result_next;

    // Read side
    logic [AW-1:0] raddr, fend_raddr;
    logic [LW-1:0] blen_q_reg, fend_q_reg;
    logic          bsy_q_reg;
    logic [LW-1:0] blen_rd, fend_rd;
    logic          bsy_rd;

    // Write side
    logic          blen_we, bsy_we, fend_we;
    logic [AW-1:0] blen_waddr, bsy_waddr, fend_waddr;
    logic [LW-1:0] blen_wdata, fend_wdata;
    logic          bsy_wdata;

    // Request decode
    logic [12:0]   need_sum;
    logic [9:0]    k_raw;
    logic [9:0]    k_full;
    logic [AW-1:0] free_s;
    logic          free_bad;

    // Working values
    logic [LW-1:0] end_pos, end_m1, rem, start_pos9, ne, ne_m1;
    logic [LW-1:0] s_ext;
    logic [11:0]   addr_calc;
    logic          split;

    always_ff @(posedge clk)
    begin
        if (blen_we)
        begin
            blen_mem[blen_waddr] <= blen_wdata;
        end
        if (bsy_we)
        begin
            bsy_mem[bsy_waddr] <= bsy_wdata;
        end
        if (fend_we)
        begin
            fend_mem[fend_waddr] <= fend_wdata;
        end
        blen_q_reg <= blen_mem[raddr];
        bsy_q_reg  <= bsy_mem[raddr];
        fend_q_reg <= fend_mem[fend_raddr];
    end

    assign blen_rd = blen_q_reg;
    assign bsy_rd  = bsy_q_reg;
    assign fend_rd = fend_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        rest_reg   <= rest_next;
        n_reg      <= n_next;
        result_reg <= result_next;
    end

    // Size in granules: header added, raised to the minimum, rounded up.
    assign need_sum = {1'b0, request.request_bytes}
                      + 13'(ffba_pkg::HEADER_BYTES + ffba_pkg::GRANULE_BYTES - 1);
    assign k_raw    = need_sum[12:3];
    assign k_full   = (k_raw < 10'(ffba_pkg::MIN_GRANULES))
                      ? 10'(ffba_pkg::MIN_GRANULES) : k_raw;

    // A valid data address is header-aligned; the block starts one granule lower.
    assign free_bad = (request.free_address < 11'(ffba_pkg::HEADER_BYTES))
                      || (request.free_address[2:0] != 3'd0);
    assign free_s   = request.free_address[10:3] - AW'(1);

    assign s_ext = {1'b0, pos_reg};

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        rest_next   = rest_reg;
        n_next      = n_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        raddr      = pos_reg;
        fend_raddr = pos_reg - AW'(1);

        blen_we    = 1'b0;
        blen_waddr = pos_reg;
        blen_wdata = '0;
        bsy_we     = 1'b0;
        bsy_waddr  = pos_reg;
        bsy_wdata  = 1'b0;
        fend_we    = 1'b0;
        fend_waddr = pos_reg;
        fend_wdata = '0;

        end_pos    = s_ext + blen_rd;
        end_m1     = end_pos - LW'(1);
        rem        = blen_rd - k_reg;
        split      = rem >= ffba_pkg::LEN_MIN;
        start_pos9 = split ? (s_ext + rem) : s_ext;
        ne         = {1'b0, n_reg} + blen_rd;
        ne_m1      = ne - LW'(1);
        addr_calc  = {1'b0, start_pos9[AW-1:0], 3'b000} + 12'(ffba_pkg::HEADER_BYTES);

        unique case (state_reg)
            // One entry of each table per cycle; the arena ends up as one free block.
            ST_CLR:
            begin
                blen_we    = 1'b1;
                blen_waddr = clr_reg;
                blen_wdata = (clr_reg == '0) ? ffba_pkg::LEN_ARENA : '0;
                bsy_we     = 1'b1;
                bsy_waddr  = clr_reg;
                bsy_wdata  = 1'b0;
                fend_we    = 1'b1;
                fend_waddr = clr_reg;
                fend_wdata = (clr_reg == '1) ? ffba_pkg::LEN_ARENA : '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    result_next.data_address = '0;
                    if (request.cmd == ffba_pkg::CMD_ALLOC)
                    begin
                        raddr    = '0;
                        pos_next = '0;
                        k_next   = k_full[LW-1:0];
                        if (k_full > 10'(ffba_pkg::GRANULES))
                        begin
                            result_next.status = ffba_pkg::STATUS_NO_FIT;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_ACHK;
                        end
                    end
                    else
                    begin
                        raddr      = free_s;
                        fend_raddr = free_s - AW'(1);
                        pos_next   = free_s;
                        if (free_bad)
                        begin
                            result_next.status = ffba_pkg::STATUS_BAD_FREE;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_FCHK;
                        end
                    end
                end
            end

            // One block of the first-fit walk per cycle; the next read is
            // issued at the end of the current block.
            ST_ACHK:
            begin
                if (blen_rd == '0 || end_pos > ffba_pkg::LEN_ARENA)
                begin
                    result_next.status = ffba_pkg::STATUS_NO_FIT;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else if (!bsy_rd && blen_rd >= k_reg)
                begin
                    fend_we    = 1'b1;
                    fend_waddr = end_m1[AW-1:0];
                    fend_wdata = '0;
                    bsy_we     = 1'b1;
                    bsy_waddr  = start_pos9[AW-1:0];
                    bsy_wdata  = 1'b1;
                    result_next.data_address = addr_calc[10:0];
                    if (split)
                    begin
                        blen_we    = 1'b1;
                        blen_waddr = pos_reg;
                        blen_wdata = rem;
                        rest_next  = rem;
                        pos_next   = start_pos9[AW-1:0];
                        state_next = ST_AW2;
                    end
                    else
                    begin
                        result_next.status = ffba_pkg::STATUS_DONE;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
                else if (end_pos >= ffba_pkg::LEN_ARENA)
                begin
                    result_next.status = ffba_pkg::STATUS_NO_FIT;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    raddr    = end_pos[AW-1:0];
                    pos_next = end_pos[AW-1:0];
                end
            end

            // Split tail: pos_reg now holds the start of the busy part.
            ST_AW2:
            begin
                fend_we    = 1'b1;
                fend_waddr = pos_reg - AW'(1);
                fend_wdata = rest_reg;
                blen_we    = 1'b1;
                blen_waddr = pos_reg;
                blen_wdata = k_reg;
                result_next.status = ffba_pkg::STATUS_DONE;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_FCHK:
            begin
                if (blen_rd == '0 || !bsy_rd || end_pos > ffba_pkg::LEN_ARENA)
                begin
                    result_next.status = ffba_pkg::STATUS_BAD_FREE;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    bsy_we    = 1'b1;
                    bsy_waddr = pos_reg;
                    bsy_wdata = 1'b0;
                    len_next  = blen_rd;
                    if (pos_reg != '0 && fend_rd != '0 && fend_rd <= s_ext)
                    begin
                        // Merge with the free block below.
                        fend_we    = 1'b1;
                        fend_waddr = pos_reg - AW'(1);
                        fend_wdata = '0;
                        blen_we    = 1'b1;
                        blen_waddr = pos_reg;
                        blen_wdata = '0;
                        raddr      = pos_reg - fend_rd[AW-1:0];
                        pos_next   = pos_reg - fend_rd[AW-1:0];
                        state_next = ST_FPREV;
                    end
                    else
                    begin
                        state_next = ST_FNRD;
                    end
                end
            end

            ST_FPREV:
            begin
                len_next   = len_reg + blen_rd;
                state_next = ST_FNRD;
            end

            ST_FNRD:
            begin
                if ((s_ext + len_reg) >= ffba_pkg::LEN_ARENA)
                begin
                    state_next = ST_FWR;
                end
                else
                begin
                    raddr      = pos_reg + len_reg[AW-1:0];
                    n_next     = pos_reg + len_reg[AW-1:0];
                    state_next = ST_FNCHK;
                end
            end

            ST_FNCHK:
            begin
                if (blen_rd != '0 && !bsy_rd && ne <= ffba_pkg::LEN_ARENA)
                begin
                    // Merge with the free block above.
                    blen_we    = 1'b1;
                    blen_waddr = n_reg;
                    blen_wdata = '0;
                    fend_we    = 1'b1;
                    fend_waddr = ne_m1[AW-1:0];
                    fend_wdata = '0;
                    len_next   = len_reg + blen_rd;
                end
                state_next = ST_FWR;
            end

            ST_FWR:
            begin
                blen_we    = 1'b1;
                blen_waddr = pos_reg;
                blen_wdata = len_reg;
                fend_we    = 1'b1;
                fend_waddr = pos_reg + len_reg[AW-1:0] - AW'(1);
                fend_wdata = len_reg;
                result_next.status = ffba_pkg::STATUS_DONE;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ test/tb_first_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit: self-checking bench of the block allocator
// Sends allocate and free command words and keeps its own copy of the three
// block tables to work out every result word. Directed cases cover the size
// extremes, bad frees and merging. A long random phase follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_WORDS = 1000;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    ffba_req_t request = '0;
    logic      busy;
    logic      done;
    ffba_rsp_t result;

    // Arena tables as the allocator keeps them, lengths in granules.
    logic [LEN_W-1:0] blk_len_at_start [GRANULES];
    logic             blk_busy         [GRANULES];
    logic [LEN_W-1:0] free_len_at_end  [GRANULES];

    ffba_rsp_t   expected_results [$];
    logic [10:0] live_addresses   [$];
    logic [10:0] freed_addresses  [$];
    ffba_rsp_t   oldest_result;

    int error_count  = 0;
    int cycle_count  = 0;
    int grants       = 0;
    int refusals     = 0;
    int frees_done   = 0;
    int bad_frees    = 0;
    bit sender_idles = 1'b1;

    first_fit_block_allocator_unit u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // First-fit walk over the block chain; the busy part goes at the high end.
    function automatic ffba_rsp_t predict_alloc(input logic [11:0] payload);
        ffba_rsp_t rsp;
        int need, pos, len, want, rest, busy_g;
        rsp = '0;
        rsp.status = STATUS_NO_FIT;
        need = int'(payload) + HEADER_BYTES;
        if (need < MIN_BLOCK_BYTES)
            need = MIN_BLOCK_BYTES;
        if (need % GRANULE_BYTES != 0)
            need += GRANULE_BYTES - need % GRANULE_BYTES;
        if (need > ARENA_BYTES)
            return rsp;
        pos = 0;
        while (pos < GRANULES)
        begin
            len = int'(blk_len_at_start[pos]);
            if (len == 0 || pos + len > GRANULES)
                break;
            if (!blk_busy[pos] && len * GRANULE_BYTES >= need)
            begin
                want = need / GRANULE_BYTES;
                free_len_at_end[pos + len - 1] = '0;
                if (len * GRANULE_BYTES - need >= MIN_BLOCK_BYTES)
                begin
                    rest = len - want;
                    blk_len_at_start[pos] = LEN_W'(rest);
                    free_len_at_end[pos + rest - 1] = LEN_W'(rest);
                    busy_g = pos + rest;
                    blk_len_at_start[busy_g] = LEN_W'(want);
                end
                else
                begin
                    busy_g = pos;
                end
                blk_busy[busy_g] = 1'b1;
                rsp.data_address = 11'(busy_g * GRANULE_BYTES + HEADER_BYTES);
                rsp.status = STATUS_DONE;
                return rsp;
            end
            pos += len;
        end
        return rsp;
    endfunction

    // Releases a busy block and merges it with free neighbors on both sides.
    function automatic ffba_rsp_t predict_free(input logic [10:0] address);
        ffba_rsp_t rsp;
        int offset, first, len, lower, nbr, nbr_len;
        rsp = '0;
        rsp.status = STATUS_BAD_FREE;
        if (int'(address) < HEADER_BYTES)
            return rsp;
        offset = int'(address) - HEADER_BYTES;
        if (offset % GRANULE_BYTES != 0 || offset / GRANULE_BYTES >= GRANULES)
            return rsp;
        first = offset / GRANULE_BYTES;
        len = int'(blk_len_at_start[first]);
        if (len == 0 || !blk_busy[first] || first + len > GRANULES)
            return rsp;
        blk_busy[first] = 1'b0;
        if (first > 0 && free_len_at_end[first - 1] != 0
            && int'(free_len_at_end[first - 1]) <= first)
        begin
            lower = first - int'(free_len_at_end[first - 1]);
            free_len_at_end[first - 1] = '0;
            blk_len_at_start[first] = '0;
            len += int'(blk_len_at_start[lower]);
            first = lower;
        end
        if (first + len < GRANULES)
        begin
            nbr = first + len;
            nbr_len = int'(blk_len_at_start[nbr]);
            if (nbr_len != 0 && !blk_busy[nbr] && nbr + nbr_len <= GRANULES)
            begin
                blk_len_at_start[nbr] = '0;
                free_len_at_end[nbr + nbr_len - 1] = '0;
                len += nbr_len;
            end
        end
        blk_len_at_start[first] = LEN_W'(len);
        free_len_at_end[first + len - 1] = LEN_W'(len);
        rsp.status = STATUS_DONE;
        return rsp;
    endfunction

    task automatic send_word(input ffba_req_t word, output ffba_rsp_t predicted);
        while (sender_idles && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= word;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (word.cmd == CMD_ALLOC)
            predicted = predict_alloc(word.request_bytes);
        else
            predicted = predict_free(word.free_address);
        expected_results.push_back(predicted);
    endtask

    task automatic send_alloc(input int payload);
        ffba_req_t word;
        ffba_rsp_t predicted;
        word.cmd           = CMD_ALLOC;
        word.request_bytes = 12'(payload);
        word.free_address  = 11'($urandom);
        send_word(word, predicted);
        if (predicted.status == STATUS_DONE)
            live_addresses.push_back(predicted.data_address);
    endtask

    task automatic send_free(input logic [10:0] address);
        ffba_req_t word;
        ffba_rsp_t predicted;
        int i;
        word.cmd           = CMD_FREE;
        word.request_bytes = 12'($urandom);
        word.free_address  = address;
        send_word(word, predicted);
        if (predicted.status == STATUS_DONE)
        begin
            for (i = 0; i < live_addresses.size(); i++)
            begin
                if (live_addresses[i] == address)
                begin
                    live_addresses.delete(i);
                    break;
                end
            end
            freed_addresses.push_back(address);
            if (freed_addresses.size() > 16)
                void'(freed_addresses.pop_front());
        end
    endtask

    // Holds the sender off until every outstanding result word has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected: data_address %0d status %0d",
                         $time, result.data_address, result.status);
                error_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (result.data_address !== oldest_result.data_address)
                begin
                    $display("%0t: data_address expected %0d actual %0d",
                             $time, oldest_result.data_address, result.data_address);
                    error_count++;
                end
                if (result.status !== oldest_result.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest_result.status, result.status);
                    error_count++;
                end
                if (oldest_result.status == STATUS_NO_FIT)
                    refusals++;
                else if (oldest_result.status == STATUS_BAD_FREE)
                    bad_frees++;
                else if (oldest_result.data_address != 0)
                    grants++;
                else
                    frees_done++;
            end
        end
    end

    // Each directed test starts and ends with the whole arena free.
    task automatic test_size_extremes();
        send_alloc(2040);   // exactly the arena, given whole
        send_alloc(0);      // nothing left
        send_free(11'd8);
        send_alloc(2048);   // rounds past the arena
        send_alloc(4095);
        send_alloc(0);      // zero bytes still takes a minimum block
        send_alloc(1992);   // remainder too small to split off
        send_free(11'd8);
        send_free(11'd2008);
        wait_all_results();
    endtask

    task automatic test_bad_frees();
        send_free(11'd0);      // below the header
        send_free(11'd9);      // off the granule grid
        send_free(11'd2047);
        send_free(11'd2040);   // no block starts there
        send_free(11'd8);      // start of a free block
        wait_all_results();
    endtask

    task automatic test_merges();
        int i;
        for (i = 0; i < 5; i++)
            send_alloc(40);
        send_free(11'd1960);   // both neighbors busy
        send_free(11'd2008);   // merges downward only
        send_free(11'd1864);   // isolated again
        send_free(11'd1912);   // merges on both sides
        send_free(11'd1816);   // joins the low free block and the upper one
        send_free(11'd2008);   // double free
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int n, roll, alloc_share, size_roll, payload;
        logic [10:0] address;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            sender_idles = !(n >= 300 && n < 500);
            if (n % 250 == 249)
                wait_all_results();
            roll = $urandom_range(99);
            alloc_share = (live_addresses.size() < 10) ? 60 : 35;
            if (roll < alloc_share)
            begin
                size_roll = $urandom_range(99);
                if (size_roll < 70)
                    payload = $urandom_range(120);
                else if (size_roll < 90)
                    payload = $urandom_range(600, 121);
                else if (size_roll < 98)
                    payload = $urandom_range(2040, 601);
                else
                    payload = $urandom_range(4095, 2041);
                send_alloc(payload);
            end
            else if (roll < 88 && live_addresses.size() != 0)
            begin
                send_free(live_addresses[$urandom_range(live_addresses.size() - 1)]);
            end
            else
            begin
                // Stale or arbitrary addresses; most of these are refused.
                if (freed_addresses.size() != 0 && $urandom_range(1) == 0)
                    address = freed_addresses[$urandom_range(freed_addresses.size() - 1)];
                else
                    address = 11'($urandom_range(2047));
                send_free(address);
            end
        end
        sender_idles = 1'b1;
        wait_all_results();
    endtask

    initial
    begin
        for (int g = 0; g < GRANULES; g++)
        begin
            blk_len_at_start[g] = '0;
            blk_busy[g]         = 1'b0;
            free_len_at_end[g]  = '0;
        end
        blk_len_at_start[0]           = LEN_ARENA;
        free_len_at_end[GRANULES - 1] = LEN_ARENA;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_extremes();
        test_bad_frees();
        test_merges();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d result words: %0d allocations granted, %0d refused,",
                 grants + refusals + frees_done + bad_frees, grants, refusals);
        $display("%0d blocks freed and merged, %0d bad or repeated frees flagged.",
                 frees_done, bad_frees);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
